[rtl/core/pli_pkg.sv]
package pli_pkg;

    // Table geometry
    localparam int MAX_POINTS    = 64;
    localparam int IDX_W         = $clog2(MAX_POINTS);
    localparam int CNT_W         = $clog2(MAX_POINTS + 1);
    localparam int DATA_W        = 16;
    localparam int FRACTION_BITS = 8;

    // Result and arithmetic widths
    localparam int Y_W   = 24;
    localparam int DIFF_W = DATA_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int NUM_W  = PROD_W + FRACTION_BITS;
    localparam int DEN_W  = DATA_W;
    localparam int QUO_W  = DATA_W + FRACTION_BITS + 2;
    localparam int SUM_W  = QUO_W + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);

    // Stream payload widths
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 32;

    // Item kinds carried on s_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MONO = 2'd1;
    localparam logic [1:0] ST_FEW  = 2'd2;

    // Saturation limits of the Q16.8 result
    localparam logic signed [SUM_W-1:0] Y_MAX = SUM_W'((1 << (Y_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] Y_MIN = -SUM_W'(1 << (Y_W - 1));

endpackage

[rtl/core/pli_table.sv]
module pli_table
    import pli_pkg::*;
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_addr,
    input  logic signed [DATA_W-1:0] wr_x,
    input  logic signed [DATA_W-1:0] wr_y,
    input  logic [IDX_W-1:0]         rd_addr,
    output logic signed [DATA_W-1:0] rd_x,
    output logic signed [DATA_W-1:0] rd_y
);

    logic signed [DATA_W-1:0] x_mem [MAX_POINTS];
    logic signed [DATA_W-1:0] y_mem [MAX_POINTS];
    logic signed [DATA_W-1:0] rd_x_reg;
    logic signed [DATA_W-1:0] rd_y_reg;

    // One write port, one registered read port shared by both columns
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
    end

    assign rd_x = rd_x_reg;
    assign rd_y = rd_y_reg;

endmodule

[rtl/core/pli_div.sv]
module pli_div
    import pli_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic                    neg,
    output logic [QUO_W-1:0]        quo
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              neg_reg;
    logic [NUM_W-1:0]  mag_reg;
    logic [DEN_W-1:0]  rem_reg;

    logic [NUM_W-1:0]  num_abs;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    trial_sub;
    logic              trial_ge;

    assign num_abs   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign trial     = {rem_reg, mag_reg[NUM_W-1]};
    assign trial_sub = trial - {1'b0, den};
    assign trial_ge  = (trial >= {1'b0, den});

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= num_abs;
            rem_reg <= '0;
            neg_reg <= num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            mag_reg <= {mag_reg[NUM_W-2:0], trial_ge};
        end
    end

    assign done = done_reg;
    assign neg  = neg_reg;
    assign quo  = mag_reg[QUO_W-1:0];

endmodule

[rtl/core/piecewise_linear_interpolator.sv]
// Piecewise-linear table interpolator.
//
// Slave stream (s_tvalid/s_tready/s_tdata/s_tuser): s_tuser selects the kind
// of transaction. A write transaction stores one breakpoint (x, y) at
// point_index and produces no result. A query transaction clamps query_x into
// the table range, walks the segments in order and returns one result on the
// master stream: interp_y in signed Q16.8 with the quotient truncated toward
// zero, a status code and the lower index of the segment used.
// Config channel (cfg_valid/cfg_ready/cfg_data) sets point_count; write it
// only while the block is idle. cfg_ready is always high.
// Transaction flow: a write is stored as it is accepted and the next
// transaction may follow at once. A query holds s_tready low until it is done.
// One that finds its segment walks 1 to 63 segments: the walk reads one
// table entry a cycle through the single memory read port, and the serial
// divider then produces 42 quotient bits and flags done. A monotonic error
// returns once the walk finds it; a short table skips the walk and divide.
// Reset clears the sequencer, point_count and the output valid; table entries
// hold anything until written. A stalled master side holds the result in the
// output register; a following query finishes and then waits for it to drain.
module piecewise_linear_interpolator
    import pli_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // tdata: point_index[5:0], point_x[21:6], point_y[37:22], query_x[53:38],
    //        zero pad[55:54]
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    // tuser: operation[0]
    input  logic                s_tuser,
    // tdata: interp_y[23:0], status[25:24], segment_index[31:26]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CNT_W-1:0]    cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_FIRST = 10'b00_0000_0010,
        S_LAST  = 10'b00_0000_0100,
        S_CLAMP = 10'b00_0000_1000,
        S_WALK  = 10'b00_0001_0000,
        S_MUL   = 10'b00_0010_0000,
        S_START = 10'b00_0100_0000,
        S_DIVW  = 10'b00_1000_0000,
        S_SUM   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Control registers
    logic [CNT_W-1:0]    point_count_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // Datapath registers
    logic signed [DATA_W-1:0] qx_reg;
    logic signed [DATA_W-1:0] xq_reg;
    logic signed [DATA_W-1:0] prev_x_reg;
    logic signed [DATA_W-1:0] prev_y_reg;
    logic signed [DATA_W-1:0] yi_reg;
    logic [IDX_W-1:0]         last_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [DEN_W-1:0]         dx_reg;
    logic [DATA_W-1:0]        d_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [QUO_W-1:0]  q_reg;
    logic signed [Y_W-1:0]    res_y_reg;
    logic [1:0]               res_status_reg;
    logic [IDX_W-1:0]         res_seg_reg;

    // Input field views
    logic [IDX_W-1:0]         point_index;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] query_x;

    logic                     s_accept;
    logic                     out_free;
    logic [CNT_W-1:0]         n_use;
    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         walk_addr;
    logic signed [DATA_W-1:0] rd_x;
    logic signed [DATA_W-1:0] rd_y;
    logic signed [DIFF_W-1:0] x_diff;
    logic signed [DIFF_W-1:0] xq_diff;
    logic                     mono_err;
    logic                     seg_hit;
    logic                     seg_end;
    logic                     div_start;
    logic                     div_done;
    logic                     div_neg;
    logic [QUO_W-1:0]         div_quo;
    logic signed [NUM_W-1:0]  div_num;
    logic signed [SUM_W-1:0]  y_sum;

    assign point_index = s_tdata[IDX_W-1:0];
    assign point_x     = s_tdata[IDX_W+DATA_W-1:IDX_W];
    assign point_y     = s_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W];
    assign query_x     = s_tdata[IDX_W+3*DATA_W-1:IDX_W+2*DATA_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Limit the point count to the table depth
    assign n_use = (point_count_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                         : point_count_reg;

    // Segment walk: rd_x/rd_y hold entry idx+1, prev holds entry idx
    assign walk_addr = IDX_W'({1'b0, idx_reg} + (IDX_W + 1)'(2));
    assign x_diff    = DIFF_W'(rd_x) - DIFF_W'(prev_x_reg);
    assign xq_diff   = DIFF_W'(xq_reg) - DIFF_W'(prev_x_reg);
    assign mono_err  = x_diff[DIFF_W-1] || (x_diff == '0);
    assign seg_hit   = (prev_x_reg <= xq_reg) && (rd_x > xq_reg);
    assign seg_end   = (({1'b0, idx_reg} + (IDX_W + 1)'(1)) == {1'b0, last_reg});

    // Scale the product by the fraction bits ahead of the divide
    assign div_num = {prod_reg, {FRACTION_BITS{1'b0}}};

    assign y_sum = {{(SUM_W - DATA_W - FRACTION_BITS){yi_reg[DATA_W-1]}}, yi_reg,
                    {FRACTION_BITS{1'b0}}} + SUM_W'(q_reg);

    pli_table u_table (
        .clk     (clk),
        .wr_en   (s_accept && (s_tuser == OP_WRITE)),
        .wr_addr (point_index),
        .wr_x    (point_x),
        .wr_y    (point_y),
        .rd_addr (rd_addr),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    pli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (dx_reg),
        .done  (div_done),
        .neg   (div_neg),
        .quo   (div_quo)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        rd_addr    = '0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept && (s_tuser == OP_QUERY))
                begin
                    state_next = (n_use < CNT_W'(2)) ? S_OUT : S_FIRST;
                end
            end
            S_FIRST:
            begin
                state_next = S_LAST;
            end
            S_LAST:
            begin
                rd_addr    = last_reg;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                rd_addr    = IDX_W'(1);
                state_next = S_WALK;
            end
            S_WALK:
            begin
                rd_addr = walk_addr;
                if (mono_err)
                begin
                    state_next = S_OUT;
                end
                else if (seg_hit || seg_end)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                point_count_reg <= cfg_data;
            end
            // Load a finished result, drop valid once it is taken
            if ((state_reg == S_OUT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept && (s_tuser == OP_QUERY))
                begin
                    qx_reg         <= query_x;
                    last_reg       <= IDX_W'(n_use - CNT_W'(1));
                    res_y_reg      <= '0;
                    res_status_reg <= ST_FEW;
                    res_seg_reg    <= '0;
                end
            end
            S_LAST:
            begin
                // Clamp below at the first breakpoint
                xq_reg     <= (qx_reg < rd_x) ? rd_x : qx_reg;
                prev_x_reg <= rd_x;
                prev_y_reg <= rd_y;
            end
            S_CLAMP:
            begin
                // Clamp above at the last breakpoint
                if (xq_reg >= rd_x)
                begin
                    xq_reg <= rd_x;
                end
                idx_reg <= '0;
            end
            S_WALK:
            begin
                if (mono_err)
                begin
                    res_y_reg      <= '0;
                    res_status_reg <= ST_MONO;
                    res_seg_reg    <= idx_reg;
                end
                else if (seg_hit || seg_end)
                begin
                    dx_reg      <= x_diff[DEN_W-1:0];
                    d_reg       <= xq_diff[DATA_W-1:0];
                    dy_reg      <= DIFF_W'(rd_y) - DIFF_W'(prev_y_reg);
                    yi_reg      <= prev_y_reg;
                    res_seg_reg <= idx_reg;
                end
                else
                begin
                    idx_reg    <= IDX_W'({1'b0, idx_reg} + (IDX_W + 1)'(1));
                    prev_x_reg <= rd_x;
                    prev_y_reg <= rd_y;
                end
            end
            S_MUL:
            begin
                prod_reg <= dy_reg * $signed({1'b0, d_reg});
            end
            S_START:
            begin
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    q_reg <= div_neg ? -$signed(div_quo) : $signed(div_quo);
                end
            end
            S_SUM:
            begin
                res_status_reg <= ST_OK;
                if (y_sum > Y_MAX)
                begin
                    res_y_reg <= Y_MAX[Y_W-1:0];
                end
                else if (y_sum < Y_MIN)
                begin
                    res_y_reg <= Y_MIN[Y_W-1:0];
                end
                else
                begin
                    res_y_reg <= y_sum[Y_W-1:0];
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {res_seg_reg, res_status_reg, res_y_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[rtl/core/pli_checker.sv]
module pli_checker
    import pli_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Drop ready after a query transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_QUERY) |=> !s_tready)
        else $error("ready held during query");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[25:24] == ST_OK) || (m_tdata[25:24] == ST_MONO)
                     || (m_tdata[25:24] == ST_FEW))
        else $error("undefined status code");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[25:24] != ST_OK) |-> (m_tdata[23:0] == '0))
        else $error("error result carries nonzero value");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[25:24] == ST_FEW) |-> (m_tdata[31:26] == '0))
        else $error("short table result carries a segment");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (.*);
